/* sv/tcwc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwc_pkg: shared types and constants
// Field widths, default fraction width and the control flags that travel
// with a transaction through the remainder cells.
// ----------------------------------------------------------------------------
package tcwc_pkg;

  localparam int unsigned TIME_W        = 32;
  localparam int unsigned SPEED_W       = 24;
  localparam int unsigned STEP_W        = 24;
  localparam int unsigned PROD_W        = SPEED_W + STEP_W;
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic neg;      // sum was negative, remainder needs folding
    logic use_mod;  // result comes from the remainder chain
    logic last;     // last track of the batch
  } tcwc_flags_t;

endpackage

/* sv/tcwc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwc_front: advance front end
// Stage A multiplies speed by step; stage B floors the product, adds it to
// the time, resolves the clamp and pass cases and forms the sum magnitude.
// ----------------------------------------------------------------------------
module tcwc_front #(
  parameter int unsigned FRAC_BITS = tcwc_pkg::FRAC_BITS_DEF,
  parameter int unsigned MAG_W     = 33
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic [tcwc_pkg::TIME_W-1:0]            old_time_i,
  input  logic signed [tcwc_pkg::SPEED_W-1:0]    play_speed_i,
  input  logic [tcwc_pkg::STEP_W-1:0]            step_length_i,
  input  logic [tcwc_pkg::TIME_W-1:0]            track_length_i,
  input  logic                                   occupied_i,
  input  logic                                   looping_i,
  input  logic                                   last_track_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output logic [MAG_W-1:0]                       mag_o,
  output logic [tcwc_pkg::TIME_W-1:0]            dur_o,
  output logic [tcwc_pkg::TIME_W-1:0]            pass_o,
  output tcwc_pkg::tcwc_flags_t                  flags_o
);

  localparam int unsigned SUM_W = MAG_W + 1;
  localparam int unsigned DEL_W = tcwc_pkg::PROD_W - FRAC_BITS;

  // stage A
  logic                                 a_valid_q;
  logic                                 a_ready;
  logic signed [tcwc_pkg::PROD_W-1:0]   prod_q;
  logic [tcwc_pkg::TIME_W-1:0]          a_old_q, a_dur_q;
  logic                                 a_occ_q, a_loop_q, a_last_q;
  logic signed [tcwc_pkg::PROD_W-1:0]   prod_d;

  // stage B
  logic                                 b_valid_q;
  logic                                 ready_o_b;
  logic signed [tcwc_pkg::PROD_W-1:0]   prod_sh;
  logic signed [DEL_W-1:0]              delta;
  logic signed [SUM_W-1:0]              sum, dur_s, neg_sum;
  logic [tcwc_pkg::TIME_W-1:0]          pass_d;
  logic [MAG_W-1:0]                     mag_d;

  assign prod_d = $signed({{tcwc_pkg::STEP_W{play_speed_i[tcwc_pkg::SPEED_W-1]}}, play_speed_i})
                * $signed({{tcwc_pkg::SPEED_W{1'b0}}, step_length_i});

  assign a_ready   = !a_valid_q || ready_o_b;
  assign ready_o_b = !b_valid_q || ready_i;
  assign ready_o   = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      prod_q   <= prod_d;
      a_old_q  <= old_time_i;
      a_dur_q  <= track_length_i;
      a_occ_q  <= occupied_i;
      a_loop_q <= looping_i;
      a_last_q <= last_track_i;
    end
  end

  // arithmetic shift floors toward minus infinity
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign delta   = prod_sh[DEL_W-1:0];
  assign sum     = $signed({{(SUM_W - tcwc_pkg::TIME_W){1'b0}}, a_old_q})
                 + SUM_W'(delta);
  assign dur_s   = $signed({{(SUM_W - tcwc_pkg::TIME_W){1'b0}}, a_dur_q});
  assign neg_sum = -sum;
  assign mag_d   = sum[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum[MAG_W-1:0];

  always_comb begin
    if (!a_occ_q) begin
      pass_d = a_old_q;
    end else if (a_dur_q == '0) begin
      pass_d = '0;
    end else if (sum[SUM_W-1]) begin
      pass_d = '0;
    end else if (sum > dur_s) begin
      pass_d = a_dur_q;
    end else begin
      pass_d = sum[tcwc_pkg::TIME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (ready_o_b) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o_b && a_valid_q) begin
      mag_o           <= mag_d;
      dur_o           <= a_dur_q;
      pass_o          <= pass_d;
      flags_o.neg     <= sum[SUM_W-1];
      flags_o.use_mod <= a_occ_q && a_loop_q && (a_dur_q != '0);
      flags_o.last    <= a_last_q;
    end
  end

  assign valid_o = b_valid_q;

endmodule

/* sv/tcwc_mod_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcwc_mod_cell: one restoring remainder cell
// Subtracts the duration shifted by SHIFT when it fits, then registers.
// ----------------------------------------------------------------------------
module tcwc_mod_cell #(
  parameter int unsigned MAG_W = 33,
  parameter int unsigned SHIFT = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [MAG_W-1:0]              rem_i,
  input  logic [tcwc_pkg::TIME_W-1:0]   dur_i,
  input  logic [tcwc_pkg::TIME_W-1:0]   pass_i,
  input  tcwc_pkg::tcwc_flags_t         flags_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [MAG_W-1:0]              rem_o,
  output logic [tcwc_pkg::TIME_W-1:0]   dur_o,
  output logic [tcwc_pkg::TIME_W-1:0]   pass_o,
  output tcwc_pkg::tcwc_flags_t         flags_o
);

  logic             valid_q;
  logic [MAG_W-1:0] dur_ext, rem_d;

  assign dur_ext = {{(MAG_W - tcwc_pkg::TIME_W){1'b0}}, dur_i};
  assign rem_d   = ((rem_i >> SHIFT) >= dur_ext) ? rem_i - (dur_ext << SHIFT) : rem_i;
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_o   <= rem_d;
      dur_o   <= dur_i;
      pass_o  <= pass_i;
      flags_o <= flags_i;
    end
  end

  assign valid_o = valid_q;

endmodule

/* sv/track_clock_wrap_or_clamp_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_clock_wrap_or_clamp_unit: per-track playback clock advance
// Adds speed times step to a track time, then wraps or clamps to the track.
// ----------------------------------------------------------------------------
// Streams one track per cycle: a transaction is taken every cycle that the
// output side keeps up. Its result passes in order a multiply stage, a
// sum/clamp stage, the remainder chain with one cell per possible quotient
// bit of the floor modulo, and an output register.
// Every stage holds its transaction under backpressure and frees itself as
// soon as its successor takes the data, so bubbles collapse and new tracks
// keep entering while a finished result waits. Unoccupied tracks pass their
// time unchanged, zero-length tracks give 0, clamped tracks saturate to
// [0, length] and looping tracks wrap by floor modulo into [0, length).
// ----------------------------------------------------------------------------
module track_clock_wrap_or_clamp_unit #(
  parameter int unsigned TIME_FRAC_BITS = tcwc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [tcwc_pkg::TIME_W-1:0]         old_time_i,
  input  logic signed [tcwc_pkg::SPEED_W-1:0] play_speed_i,
  input  logic [tcwc_pkg::STEP_W-1:0]         step_length_i,
  input  logic [tcwc_pkg::TIME_W-1:0]         track_length_i,
  input  logic                                occupied_i,
  input  logic                                looping_i,
  input  logic                                last_track_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [tcwc_pkg::TIME_W-1:0]         new_time_o,
  output logic                                last_out_o
);

  // delta has PROD_W - F signed bits, time 33 signed bits; magnitude one less
  localparam int unsigned DEL_W = tcwc_pkg::PROD_W - TIME_FRAC_BITS;
  localparam int unsigned MAG_W = (DEL_W > tcwc_pkg::TIME_W + 1) ?
                                  DEL_W : tcwc_pkg::TIME_W + 1;

  logic                          vld   [MAG_W+1];
  logic                          rdy   [MAG_W+1];
  logic [MAG_W-1:0]              rem   [MAG_W+1];
  logic [tcwc_pkg::TIME_W-1:0]   dur   [MAG_W+1];
  logic [tcwc_pkg::TIME_W-1:0]   pass  [MAG_W+1];
  tcwc_pkg::tcwc_flags_t         flags [MAG_W+1];

  tcwc_front #(
    .FRAC_BITS (TIME_FRAC_BITS),
    .MAG_W     (MAG_W)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_i),
    .ready_o        (ready_o),
    .old_time_i     (old_time_i),
    .play_speed_i   (play_speed_i),
    .step_length_i  (step_length_i),
    .track_length_i (track_length_i),
    .occupied_i     (occupied_i),
    .looping_i      (looping_i),
    .last_track_i   (last_track_i),
    .valid_o        (vld[0]),
    .ready_i        (rdy[0]),
    .mag_o          (rem[0]),
    .dur_o          (dur[0]),
    .pass_o         (pass[0]),
    .flags_o        (flags[0])
  );

  // cell k tests quotient bit MAG_W-1-k, high bits first
  for (genvar k = 0; k < MAG_W; k++) begin : g_cell
    tcwc_mod_cell #(
      .MAG_W (MAG_W),
      .SHIFT (MAG_W - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .rem_i   (rem[k]),
      .dur_i   (dur[k]),
      .pass_i  (pass[k]),
      .flags_i (flags[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .rem_o   (rem[k+1]),
      .dur_o   (dur[k+1]),
      .pass_o  (pass[k+1]),
      .flags_o (flags[k+1])
    );
  end

  // output stage: fold negative remainders, pick wrap or pass result
  logic                        out_valid_q;
  logic [tcwc_pkg::TIME_W-1:0] new_time_q, res_d, r_low, out_dur_q;
  logic                        last_q, out_mod_q;

  assign rdy[MAG_W] = !out_valid_q || ready_i;
  assign r_low      = rem[MAG_W][tcwc_pkg::TIME_W-1:0];

  always_comb begin
    if (!flags[MAG_W].use_mod) begin
      res_d = pass[MAG_W];
    end else if (flags[MAG_W].neg && (r_low != '0)) begin
      res_d = dur[MAG_W] - r_low;
    end else begin
      res_d = r_low;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[MAG_W]) begin
      out_valid_q <= vld[MAG_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[MAG_W] && vld[MAG_W]) begin
      new_time_q <= res_d;
      last_q     <= flags[MAG_W].last;
      out_dur_q  <= dur[MAG_W];
      out_mod_q  <= flags[MAG_W].use_mod;
    end
  end

  assign valid_o    = out_valid_q;
  assign new_time_o = new_time_q;
  assign last_out_o = last_q;

  // remainder chain must leave less than one duration
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[MAG_W] && flags[MAG_W].use_mod |->
      rem[MAG_W] < {{(MAG_W - tcwc_pkg::TIME_W){1'b0}}, dur[MAG_W]})
    else $error("remainder not reduced below duration");

  // wrapped result lies in [0, duration)
  a_wrap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_mod_q |-> new_time_q < out_dur_q)
    else $error("wrapped time out of range");

  // a stalled output register never lets the last cell drain
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !ready_i |-> !rdy[MAG_W])
    else $error("output stage overwritten while stalled");

endmodule

/* dv/tb_track_clock_wrap_or_clamp_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_track_clock_wrap_or_clamp_unit: self-checking bench for the track clock
// Directed corner tracks, then random tracks, go through a valid/ready driver.
// Each accepted transaction is predicted in bench-side fixed point and the
// monitor compares every result with the oldest pending expected result.
// ----------------------------------------------------------------------------
module tb_track_clock_wrap_or_clamp_unit;

  localparam int unsigned FB = tcwc_pkg::FRAC_BITS_DEF;
  // Pipeline depth is 3 + magnitude bits; DRAIN_CYC covers it with margin.
  localparam int unsigned DRAIN_CYC = 80;

  typedef struct packed {
    logic [tcwc_pkg::TIME_W-1:0]         old_time;
    logic signed [tcwc_pkg::SPEED_W-1:0] speed;
    logic [tcwc_pkg::STEP_W-1:0]         step;
    logic [tcwc_pkg::TIME_W-1:0]         dur;
    logic                                occ;
    logic                                loop_en;
    logic                                last;
  } track_t;

  typedef struct packed {
    logic [tcwc_pkg::TIME_W-1:0] new_time;
    logic                        last;
  } track_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                                valid_i = 1'b0;
  logic                                ready_o;
  logic [tcwc_pkg::TIME_W-1:0]         old_time_i = '0;
  logic signed [tcwc_pkg::SPEED_W-1:0] play_speed_i = '0;
  logic [tcwc_pkg::STEP_W-1:0]         step_length_i = '0;
  logic [tcwc_pkg::TIME_W-1:0]         track_length_i = '0;
  logic                                occupied_i = 1'b0;
  logic                                looping_i = 1'b0;
  logic                                last_track_i = 1'b0;
  logic                                valid_o;
  logic                                ready_i = 1'b0;
  logic [tcwc_pkg::TIME_W-1:0]         new_time_o;
  logic                                last_out_o;

  track_t     pending_tracks[$];
  track_res_t expected_times[$];
  int  err_cnt = 0;
  bit  stim_done = 1'b0;
  // long receiver stall, counted in the monitor
  int  rx_hold = 0;
  bit  hold_done = 1'b0;
  int  rx_cnt = 0;

  track_clock_wrap_or_clamp_unit #(.TIME_FRAC_BITS(FB)) dut (
    .clk_i, .rst_ni, .valid_i, .ready_o, .old_time_i, .play_speed_i,
    .step_length_i, .track_length_i, .occupied_i, .looping_i,
    .last_track_i, .valid_o, .ready_i, .new_time_o, .last_out_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Advance one track time: floor(speed*step / 2^F) added, then wrap/clamp.
  function automatic track_res_t advance_track(track_t t);
    track_res_t r;
    longint prod, sum, d, m;
    r.last = t.last;
    if (!t.occ) begin
      r.new_time = t.old_time;
    end else if (t.dur == 0) begin
      r.new_time = '0;
    end else begin
      prod = longint'(t.speed) * longint'({1'b0, t.step});
      sum  = longint'({1'b0, t.old_time}) + (prod >>> FB);
      d    = longint'({1'b0, t.dur});
      if (t.loop_en) begin
        m = sum % d;
        if (m < 0) m += d;
        r.new_time = m[tcwc_pkg::TIME_W-1:0];
      end else if (sum < 0) begin
        r.new_time = '0;
      end else if (sum > d) begin
        r.new_time = t.dur;
      end else begin
        r.new_time = sum[tcwc_pkg::TIME_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic track_t rand_track();
    track_t t;
    int sel;
    t.old_time = $urandom();
    t.speed    = 24'($urandom());
    t.step     = 24'($urandom());
    t.dur      = $urandom();
    t.occ      = ($urandom_range(0, 9) != 0);
    t.loop_en  = 1'($urandom_range(0, 1));
    t.last     = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 5);
    // short or zero-length tracks, speeds near unity, small steps and times near the end so wrap/clamp fire often
    if (sel == 0) t.dur = $urandom_range(1, 16);
    else if (sel == 1) t.dur = $urandom_range(1, 1 << 20);
    else if (sel == 2) t.dur = '0;
    if ($urandom_range(0, 2) == 0) t.speed = $signed(24'($urandom_range(0, 1 << 17)))
                                             - $signed(24'(1 << 16));
    if ($urandom_range(0, 2) == 0) t.step = 24'($urandom_range(0, 1 << 12));
    if ($urandom_range(0, 3) == 0) t.old_time = t.dur - $urandom_range(0, 3);
    return t;
  endfunction

  function automatic track_t mk(logic [31:0] ot, logic [23:0] sp, logic [23:0] st,
                                logic [31:0] du, logic oc, logic lp, logic ls);
    track_t t;
    t.old_time = ot; t.speed = sp; t.step = st; t.dur = du;
    t.occ = oc; t.loop_en = lp; t.last = ls;
    return t;
  endfunction

  initial begin
    // directed corners
    pending_tracks.push_back(mk(32'h1234_5678, 24'h7F_FFFF, 24'hFF_FFFF, 32'h10,
                                1'b0, 1'b1, 1'b0));
    pending_tracks.push_back(mk(32'hFFFF_FFFF, 24'h80_0000, 24'hFF_FFFF, 32'h0,
                                1'b0, 1'b0, 1'b1));
    pending_tracks.push_back(mk(32'h0001_0000, 24'h01_0000, 24'h01_0000, 32'h0,
                                1'b1, 1'b1, 1'b0));
    pending_tracks.push_back(mk(32'h0001_0000, 24'h01_0000, 24'h01_0000, 32'h0,
                                1'b1, 1'b0, 1'b1));
    pending_tracks.push_back(mk(32'h0001_0000, 24'h01_0000, 24'h01_0000, 32'h2_0000,
                                1'b1, 1'b1, 1'b0));
    pending_tracks.push_back(mk(32'h0000_0000, 24'hFF_0000, 24'h01_0000, 32'h1_0000,
                                1'b1, 1'b1, 1'b1));
    pending_tracks.push_back(mk(32'h0000_0000, 24'hFE_0000, 24'h01_0000, 32'h1_0000,
                                1'b1, 1'b1, 1'b0));
    pending_tracks.push_back(mk(32'h0000_0000, 24'h80_0000, 24'hFF_FFFF, 32'h3,
                                1'b1, 1'b1, 1'b0));
    pending_tracks.push_back(mk(32'hFFFF_FFFF, 24'h7F_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF,
                                1'b1, 1'b1, 1'b1));
    pending_tracks.push_back(mk(32'hFFFF_FFFF, 24'h7F_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF,
                                1'b1, 1'b0, 1'b0));
    pending_tracks.push_back(mk(32'h0000_0010, 24'h80_0000, 24'hFF_FFFF, 32'hFFFF_FFFF,
                                1'b1, 1'b0, 1'b1));
    pending_tracks.push_back(mk(32'h0009_0000, 24'h00_0000, 24'h01_0000, 32'h2_0000,
                                1'b1, 1'b1, 1'b0));
    pending_tracks.push_back(mk(32'h0009_0000, 24'h01_0000, 24'h00_0000, 32'h2_0000,
                                1'b1, 1'b0, 1'b0));
    pending_tracks.push_back(mk(32'h0000_8000, 24'h00_0001, 24'h00_0001, 32'h1_0000,
                                1'b1, 1'b0, 1'b1));
    pending_tracks.push_back(mk(32'h0000_8000, 24'hFF_FFFF, 24'h00_0001, 32'h1_0000,
                                1'b1, 1'b0, 1'b0));
    pending_tracks.push_back(mk(32'h0000_0000, 24'hFF_FFFF, 24'h00_0001, 32'h1,
                                1'b1, 1'b1, 1'b1));
    pending_tracks.push_back(mk(32'h0000_0000, 24'h00_0000, 24'h00_0000, 32'h1,
                                1'b1, 1'b1, 1'b0));
    for (int i = 0; i < 1700; i++) pending_tracks.push_back(rand_track());
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: one gap draw per transaction, valid held until accepted
  int tx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && ready_o) begin
        expected_times.push_back(advance_track({old_time_i, play_speed_i, step_length_i,
          track_length_i, occupied_i, looping_i, last_track_i}));
        tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (!valid_i || ready_o) begin
        if (tx_gap > 0 || pending_tracks.size() == 0) begin
          if (tx_gap > 0) tx_gap--;
          valid_i <= 1'b0;
          if (pending_tracks.size() == 0) stim_done = 1'b1;
        end else begin
          track_t t;
          t = pending_tracks.pop_front();
          valid_i        <= 1'b1;
          old_time_i     <= t.old_time;
          play_speed_i   <= t.speed;
          step_length_i  <= t.step;
          track_length_i <= t.dur;
          occupied_i     <= t.occ;
          looping_i      <= t.loop_en;
          last_track_i   <= t.last;
        end
      end
    end
  end

  // monitor: compare with the oldest expectation, random stalls on ready
  int rx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && ready_i) begin
        track_res_t e;
        rx_cnt++;
        if (expected_times.size() == 0) begin
          $error("unexpected result new_time=%h", new_time_o);
          err_cnt++;
        end else begin
          e = expected_times.pop_front();
          if (new_time_o !== e.new_time) begin
            $error("new_time expected %h actual %h", e.new_time, new_time_o);
            err_cnt++;
          end
          if (last_out_o !== e.last) begin
            $error("last_out expected %b actual %b", e.last, last_out_o);
            err_cnt++;
          end
        end
        rx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
      // one long hold-off so the pipeline fills and backs up the input
      if (!hold_done && rx_cnt == 300) begin
        hold_done = 1'b1;
        rx_hold = 200;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        ready_i <= 1'b0;
      end else begin
        ready_i <= 1'b1;
      end
    end
  end

  initial begin
    wait (rst_ni);
    wait (stim_done && !valid_i);
    wait (expected_times.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0 && expected_times.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
